// ===== hw/rtl/gbalu_pkg.sv =====
// Shared types and constants for the 8/16-bit ALU with Z/N/H/C flags.
package gbalu_pkg;

    localparam logic [3:0] CMD_ADD   = 4'd0;
    localparam logic [3:0] CMD_ADC   = 4'd1;
    localparam logic [3:0] CMD_SUB   = 4'd2;
    localparam logic [3:0] CMD_SBC   = 4'd3;
    localparam logic [3:0] CMD_AND   = 4'd4;
    localparam logic [3:0] CMD_OR    = 4'd5;
    localparam logic [3:0] CMD_XOR   = 4'd6;
    localparam logic [3:0] CMD_CP    = 4'd7;
    localparam logic [3:0] CMD_INC   = 4'd8;
    localparam logic [3:0] CMD_DEC   = 4'd9;
    localparam logic [3:0] CMD_SWAP  = 4'd10;
    localparam logic [3:0] CMD_ADD16 = 4'd11;
    localparam logic [3:0] CMD_ADDSP = 4'd12;
    localparam logic [3:0] CMD_INC16 = 4'd13;
    localparam logic [3:0] CMD_DEC16 = 4'd14;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    typedef struct packed {
        logic [3:0]  command;
        logic [7:0]  acc;
        logic [7:0]  operand;
        logic [3:0]  flags_in;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } in_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic [3:0]  flags_out;
    } out_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  acc;
        logic [3:0]  flags_in;
        logic [15:0] word_a;
        logic [7:0]  logic_res;
        logic [7:0]  add8_a;
        logic [7:0]  add8_b;
        logic        add8_cin;
        logic [15:0] add16_a;
        logic [15:0] add16_b;
        logic        add16_cin;
    } s1_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  acc;
        logic [3:0]  flags_in;
        logic [15:0] word_a;
        logic [7:0]  logic_res;
        logic [8:0]  sum8;
        logic        half8;
        logic [16:0] sum16;
        logic        half16;
    } s2_t;

endpackage

// ===== hw/rtl/cpu_alu_with_flags_core.sv =====
// Top level: three-stage pipelined 8/16-bit ALU with Z/N/H/C flags.
//
//   channel  | direction | ports                       | beat
//   ---------+-----------+-----------------------------+------------------------------
//   s_       | in        | s_valid, s_ready, s_data    | command, operands, flags
//   m_       | out       | m_valid, m_ready, m_data    | byte/word result, flags
//
// An accepted beat passes the stage 1, stage 2 and output registers in turn; one beat per
// cycle is sustained while m_ready stays high. Stages: decode/operand prep, adders, flag
// and result select (the last stage is the output register). Reset clears all stage
// valid bits. A stalled m_ready holds the output register; upstream stages keep loading
// into empty slots, so s_ready drops only when every stage is full.
module cpu_alu_with_flags_core import gbalu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic v1;
    logic v2;
    logic adv1;
    logic adv2;
    logic adv3;
    s1_t  d1;
    s2_t  d2;

    assign adv3    = !m_valid || m_ready;
    assign adv2    = !v2 || adv3;
    assign adv1    = !v1 || adv2;
    assign s_ready = adv1;

    gbalu_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv1),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (v1),
        .out_data  (d1)
    );

    gbalu_add u_add (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv2),
        .in_valid  (v1),
        .in_data   (d1),
        .out_valid (v2),
        .out_data  (d2)
    );

    gbalu_flags u_flags (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv3),
        .in_valid  (v2),
        .in_data   (d2),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    a_stage1_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1 && !v2) |=> v2)
        else $error("stage 1 beat did not advance into empty stage 2");

    a_stage2_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2 && !m_valid) |=> m_valid)
        else $error("stage 2 beat did not advance into empty output register");

endmodule

// ===== hw/rtl/gbalu_prep.sv =====
// Stage 1: command decode, adder operand forming and logic results.
module gbalu_prep import gbalu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic in_valid,
    input  in_t  in_data,
    output logic out_valid,
    output s1_t  out_data
);

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;
    logic cin;

    always_comb begin
        cin = in_data.flags_in[FLAG_C];
        data_next           = '0;
        data_next.cmd       = in_data.command;
        data_next.acc       = in_data.acc;
        data_next.flags_in  = in_data.flags_in;
        data_next.word_a    = in_data.word_a;
        data_next.add8_a    = in_data.acc;
        data_next.add8_b    = in_data.operand;
        data_next.add8_cin  = 1'b0;
        data_next.add16_a   = in_data.word_a;
        data_next.add16_b   = in_data.word_b;
        data_next.add16_cin = 1'b0;
        unique case (in_data.command)
            CMD_ADC: begin
                data_next.add8_cin = cin;
            end
            CMD_SUB, CMD_CP: begin
                data_next.add8_b   = ~in_data.operand;
                data_next.add8_cin = 1'b1;
            end
            CMD_SBC: begin
                data_next.add8_b   = ~in_data.operand;
                data_next.add8_cin = ~cin;
            end
            CMD_INC: begin
                data_next.add8_b = 8'h01;
            end
            CMD_DEC: begin
                data_next.add8_b   = 8'hFE;
                data_next.add8_cin = 1'b1;
            end
            CMD_ADDSP: begin
                data_next.add8_a  = in_data.word_a[7:0];
                data_next.add16_b = {{8{in_data.operand[7]}}, in_data.operand};
            end
            CMD_INC16: begin
                data_next.add16_b   = 16'h0000;
                data_next.add16_cin = 1'b1;
            end
            CMD_DEC16: begin
                data_next.add16_b = 16'hFFFF;
            end
            default: begin
            end
        endcase
        unique case (in_data.command)
            CMD_OR:   data_next.logic_res = in_data.acc | in_data.operand;
            CMD_XOR:  data_next.logic_res = in_data.acc ^ in_data.operand;
            CMD_SWAP: data_next.logic_res = {in_data.acc[3:0], in_data.acc[7:4]};
            default:  data_next.logic_res = in_data.acc & in_data.operand;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/gbalu_add.sv =====
// Stage 2: 8-bit and 16-bit adders with half-carry taps.
module gbalu_add import gbalu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic in_valid,
    input  s1_t  in_data,
    output logic out_valid,
    output s2_t  out_data
);

    logic        valid_reg;
    s2_t         data_reg;
    s2_t         data_next;
    logic [4:0]  nib8;
    logic [12:0] nib16;

    always_comb begin
        nib8  = {1'b0, in_data.add8_a[3:0]} + {1'b0, in_data.add8_b[3:0]}
              + {4'd0, in_data.add8_cin};
        nib16 = {1'b0, in_data.add16_a[11:0]} + {1'b0, in_data.add16_b[11:0]}
              + {12'd0, in_data.add16_cin};
        data_next           = '0;
        data_next.cmd       = in_data.cmd;
        data_next.acc       = in_data.acc;
        data_next.flags_in  = in_data.flags_in;
        data_next.word_a    = in_data.word_a;
        data_next.logic_res = in_data.logic_res;
        data_next.sum8      = {1'b0, in_data.add8_a} + {1'b0, in_data.add8_b}
                            + {8'd0, in_data.add8_cin};
        data_next.half8     = nib8[4];
        data_next.sum16     = {1'b0, in_data.add16_a} + {1'b0, in_data.add16_b}
                            + {16'd0, in_data.add16_cin};
        data_next.half16    = nib16[12];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/gbalu_flags.sv =====
// Stage 3: result selection, zero detect and flag forming into the output register.
module gbalu_flags import gbalu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic adv,
    input  logic in_valid,
    input  s2_t  in_data,
    output logic out_valid,
    output out_t out_data
);

    logic       valid_reg;
    out_t       data_reg;
    out_t       data_next;
    logic       zero8;
    logic       zero_log;
    logic       c8;
    logic       fc;
    logic [3:0] fi;

    always_comb begin
        zero8    = (in_data.sum8[7:0] == 8'h00);
        zero_log = (in_data.logic_res == 8'h00);
        c8       = in_data.sum8[8];
        fi       = in_data.flags_in;
        fc       = fi[FLAG_C];
        data_next = '0;
        unique case (in_data.cmd)
            CMD_ADD, CMD_ADC: begin
                data_next.result_byte = in_data.sum8[7:0];
                data_next.flags_out   = {zero8, 1'b0, in_data.half8, c8};
            end
            CMD_SUB, CMD_SBC: begin
                data_next.result_byte = in_data.sum8[7:0];
                data_next.flags_out   = {zero8, 1'b1, ~in_data.half8, ~c8};
            end
            CMD_CP: begin
                data_next.result_byte = in_data.acc;
                data_next.flags_out   = {zero8, 1'b1, ~in_data.half8, ~c8};
            end
            CMD_INC: begin
                data_next.result_byte = in_data.sum8[7:0];
                data_next.flags_out   = {zero8, 1'b0, in_data.half8, fc};
            end
            CMD_DEC: begin
                data_next.result_byte = in_data.sum8[7:0];
                data_next.flags_out   = {zero8, 1'b1, ~in_data.half8, fc};
            end
            CMD_AND: begin
                data_next.result_byte = in_data.logic_res;
                data_next.flags_out   = {zero_log, 1'b0, 1'b1, 1'b0};
            end
            CMD_OR, CMD_XOR, CMD_SWAP: begin
                data_next.result_byte = in_data.logic_res;
                data_next.flags_out   = {zero_log, 3'b000};
            end
            CMD_ADD16: begin
                data_next.result_word = in_data.sum16[15:0];
                data_next.flags_out   = {fi[FLAG_Z], 1'b0, in_data.half16,
                                         in_data.sum16[16]};
            end
            CMD_ADDSP: begin
                data_next.result_word = in_data.sum16[15:0];
                data_next.flags_out   = {2'b00, in_data.half8, c8};
            end
            CMD_INC16, CMD_DEC16: begin
                data_next.result_word = in_data.sum16[15:0];
                data_next.flags_out   = fi;
            end
            default: begin
                data_next.result_byte = in_data.acc;
                data_next.result_word = in_data.word_a;
                data_next.flags_out   = fi;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== verif/cpu_alu_with_flags_core_tb.sv =====
// Testbench for cpu_alu_with_flags_core: directed table and random beats against a predictor.
`timescale 1ns / 100ps

module cpu_alu_with_flags_core_tb;
    import gbalu_pkg::*;

    localparam logic [3:0] CMD_NOP = 4'd15;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 100;

    typedef enum logic [1:0] {RX_RANDOM, RX_HOLD, RX_STEADY} rx_mode_t;

    typedef struct {
        in_t  stim;
        bit   typed;
        out_t want;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    bit       beat_typed;
    out_t     beat_want;
    bit       tx_steady;
    rx_mode_t rx_mode;
    bit       hold_done;
    out_t     alu_results_q[$];
    out_t     oldest;
    dir_row_t dir_rows[$];
    int       mismatches = 0;
    int       idle_cycles = 0;

    cpu_alu_with_flags_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic out_t alu_predict(input in_t d);
        out_t        r;
        logic        cin;
        logic        ci;
        logic [8:0]  s9;
        logic [4:0]  h5;
        logic [16:0] s17;
        logic [12:0] h13;
        r = '0;
        r.flags_out = d.flags_in;
        cin = d.flags_in[FLAG_C];
        case (d.command)
            CMD_ADD, CMD_ADC: begin
                ci = (d.command == CMD_ADC) ? cin : 1'b0;
                s9 = {1'b0, d.acc} + {1'b0, d.operand} + {8'b0, ci};
                h5 = {1'b0, d.acc[3:0]} + {1'b0, d.operand[3:0]} + {4'b0, ci};
                r.result_byte = s9[7:0];
                r.flags_out = '0;
                r.flags_out[FLAG_Z] = (s9[7:0] == 8'h00);
                r.flags_out[FLAG_H] = h5[4];
                r.flags_out[FLAG_C] = s9[8];
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                ci = (d.command == CMD_SBC) ? cin : 1'b0;
                s9 = {1'b0, d.acc} - {1'b0, d.operand} - {8'b0, ci};
                h5 = {1'b0, d.acc[3:0]} - {1'b0, d.operand[3:0]} - {4'b0, ci};
                r.result_byte = (d.command == CMD_CP) ? d.acc : s9[7:0];
                r.flags_out = '0;
                r.flags_out[FLAG_Z] = (s9[7:0] == 8'h00);
                r.flags_out[FLAG_N] = 1'b1;
                r.flags_out[FLAG_H] = h5[4];
                r.flags_out[FLAG_C] = s9[8];
            end
            CMD_AND, CMD_OR, CMD_XOR, CMD_SWAP: begin
                case (d.command)
                    CMD_AND: r.result_byte = d.acc & d.operand;
                    CMD_OR:  r.result_byte = d.acc | d.operand;
                    CMD_XOR: r.result_byte = d.acc ^ d.operand;
                    default: r.result_byte = {d.acc[3:0], d.acc[7:4]};
                endcase
                r.flags_out = '0;
                r.flags_out[FLAG_Z] = (r.result_byte == 8'h00);
                r.flags_out[FLAG_H] = (d.command == CMD_AND);
            end
            CMD_INC, CMD_DEC: begin
                r.result_byte = (d.command == CMD_INC) ? d.acc + 8'd1 : d.acc - 8'd1;
                r.flags_out = '0;
                r.flags_out[FLAG_Z] = (r.result_byte == 8'h00);
                r.flags_out[FLAG_N] = (d.command == CMD_DEC);
                r.flags_out[FLAG_H] = (d.command == CMD_INC) ? (d.acc[3:0] == 4'hF)
                                                             : (d.acc[3:0] == 4'h0);
                r.flags_out[FLAG_C] = cin;
            end
            CMD_ADD16: begin
                s17 = {1'b0, d.word_a} + {1'b0, d.word_b};
                h13 = {1'b0, d.word_a[11:0]} + {1'b0, d.word_b[11:0]};
                r.result_word = s17[15:0];
                r.flags_out[FLAG_N] = 1'b0;
                r.flags_out[FLAG_H] = h13[12];
                r.flags_out[FLAG_C] = s17[16];
            end
            CMD_ADDSP: begin
                s9 = {1'b0, d.word_a[7:0]} + {1'b0, d.operand};
                h5 = {1'b0, d.word_a[3:0]} + {1'b0, d.operand[3:0]};
                r.result_word = d.word_a + {{8{d.operand[7]}}, d.operand};
                r.flags_out = '0;
                r.flags_out[FLAG_H] = h5[4];
                r.flags_out[FLAG_C] = s9[8];
            end
            CMD_INC16: r.result_word = d.word_a + 16'd1;
            CMD_DEC16: r.result_word = d.word_a - 16'd1;
            default: begin
                r.result_byte = d.acc;
                r.result_word = d.word_a;
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h0F;
            3: return 8'hF0;
            4: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(15))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0FFF;
            3: return 16'h00FF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t random_beat();
        in_t d;
        d.command  = 4'($urandom_range(15));
        d.acc      = pick_byte();
        d.operand  = pick_byte();
        d.flags_in = 4'($urandom_range(15));
        d.word_a   = pick_word();
        d.word_b   = pick_word();
        return d;
    endfunction

    task automatic add_row(input in_t stim, input bit typed, input out_t want);
        dir_row_t r;
        r.stim  = stim;
        r.typed = typed;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    task automatic send_beat(input in_t d, input bit typed, input out_t want);
        if (!tx_steady) begin
            while ($urandom_range(99) < 38) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid    <= 1'b1;
        s_data     <= d;
        beat_typed <= typed;
        beat_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (alu_results_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, m_data);
                end else begin
                    oldest = alu_results_q.pop_front();
                    if (m_data.result_byte !== oldest.result_byte)
                        flag_mismatch("result_byte", 16'(oldest.result_byte),
                                      16'(m_data.result_byte));
                    if (m_data.result_word !== oldest.result_word)
                        flag_mismatch("result_word", oldest.result_word, m_data.result_word);
                    if (m_data.flags_out !== oldest.flags_out)
                        flag_mismatch("flags_out", 16'(oldest.flags_out),
                                      16'(m_data.flags_out));
                end
            end
            if (s_valid && s_ready)
                alu_results_q.push_back(beat_typed ? beat_want : alu_predict(s_data));
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** cpu_alu_with_flags_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int hold_cycles;
        m_ready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_mode == RX_HOLD && !hold_done) begin
                m_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++)
                    @(posedge aclk);
                hold_done = 1'b1;
            end else if (rx_mode == RX_STEADY) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 38);
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        beat_typed  = 1'b0;
        beat_want   = '0;
        tx_steady   = 1'b0;
        rx_mode     = RX_RANDOM;

        add_row({CMD_ADD,   8'hFF, 8'h01, 4'b0000, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1011});
        add_row({CMD_ADD,   8'h00, 8'h00, 4'b1111, 16'hFFFF, 16'hFFFF}, 1'b1,
                {8'h00, 16'h0000, 4'b1000});
        add_row({CMD_ADC,   8'hFF, 8'h00, 4'b0001, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1011});
        add_row({CMD_ADC,   8'h0F, 8'h00, 4'b0001, 16'h0000, 16'h0000}, 1'b1,
                {8'h10, 16'h0000, 4'b0010});
        add_row({CMD_ADC,   8'h7F, 8'h80, 4'b1110, 16'h1234, 16'h0000}, 1'b0, '0);
        add_row({CMD_SUB,   8'h00, 8'h01, 4'b0000, 16'h0000, 16'h0000}, 1'b1,
                {8'hFF, 16'h0000, 4'b0111});
        add_row({CMD_SUB,   8'h55, 8'h55, 4'b0000, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1100});
        add_row({CMD_SBC,   8'h00, 8'h00, 4'b0001, 16'h0000, 16'h0000}, 1'b1,
                {8'hFF, 16'h0000, 4'b0111});
        add_row({CMD_CP,    8'h3C, 8'h3C, 4'b0000, 16'h0000, 16'h0000}, 1'b1,
                {8'h3C, 16'h0000, 4'b1100});
        add_row({CMD_CP,    8'h10, 8'h20, 4'b0000, 16'h0000, 16'h0000}, 1'b1,
                {8'h10, 16'h0000, 4'b0101});
        add_row({CMD_AND,   8'hF0, 8'h0F, 4'b0000, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1010});
        add_row({CMD_OR,    8'h00, 8'h00, 4'b1111, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1000});
        add_row({CMD_XOR,   8'hFF, 8'hFF, 4'b0000, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1000});
        add_row({CMD_INC,   8'hFF, 8'h00, 4'b0001, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1011});
        add_row({CMD_DEC,   8'h01, 8'h00, 4'b0000, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1100});
        add_row({CMD_DEC,   8'h00, 8'h00, 4'b0001, 16'h0000, 16'h0000}, 1'b1,
                {8'hFF, 16'h0000, 4'b0111});
        add_row({CMD_SWAP,  8'hA5, 8'h00, 4'b1111, 16'h0000, 16'h0000}, 1'b1,
                {8'h5A, 16'h0000, 4'b0000});
        add_row({CMD_ADD16, 8'h55, 8'h00, 4'b1000, 16'h0FFF, 16'h0001}, 1'b1,
                {8'h00, 16'h1000, 4'b1010});
        add_row({CMD_ADD16, 8'hFF, 8'h00, 4'b0100, 16'hFFFF, 16'h0001}, 1'b1,
                {8'h00, 16'h0000, 4'b0011});
        add_row({CMD_ADDSP, 8'h00, 8'h01, 4'b1111, 16'h00FF, 16'h0000}, 1'b1,
                {8'h00, 16'h0100, 4'b0011});
        add_row({CMD_ADDSP, 8'h00, 8'h80, 4'b1111, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'hFF80, 4'b0000});
        add_row({CMD_ADDSP, 8'h00, 8'hFF, 4'b0000, 16'h1234, 16'h0000}, 1'b0, '0);
        add_row({CMD_INC16, 8'h00, 8'h00, 4'b1010, 16'hFFFF, 16'h0000}, 1'b1,
                {8'h00, 16'h0000, 4'b1010});
        add_row({CMD_DEC16, 8'h00, 8'h00, 4'b0101, 16'h0000, 16'h0000}, 1'b1,
                {8'h00, 16'hFFFF, 4'b0101});
        add_row({CMD_NOP,   8'h77, 8'h00, 4'b0110, 16'hBEEF, 16'h0000}, 1'b1,
                {8'h77, 16'hBEEF, 4'b0110});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        repeat (150) send_beat(random_beat(), 1'b0, '0);

        rx_mode   = RX_HOLD;
        tx_steady = 1'b1;
        repeat (30) send_beat(random_beat(), 1'b0, '0);
        tx_steady = 1'b0;

        s_valid <= 1'b0;
        @(posedge aclk);
        while (alu_results_q.size() != 0) @(posedge aclk);

        rx_mode   = RX_STEADY;
        tx_steady = 1'b1;
        repeat (120) send_beat(random_beat(), 1'b0, '0);
        tx_steady = 1'b0;
        rx_mode   = RX_RANDOM;

        repeat (150) send_beat(random_beat(), 1'b0, '0);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (alu_results_q.size() != 0) @(posedge aclk);
        rx_mode = RX_STEADY;
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("** cpu_alu_with_flags_core: PASSED **");
        end else begin
            $display("** cpu_alu_with_flags_core: FAILED **");
        end
        $finish;
    end

endmodule
